[design/uart_rb_pkg.sv]
// ----------------------------------------------------------------------------
// UART register block package
// Shared transaction types, command and register codes, FIFO level helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package uart_rb_pkg;

  localparam int FifoDepthDef    = 32;
  localparam int TimeoutTicksDef = 32;

  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_RX    = 3'd2,
    CMD_TX    = 3'd3,
    CMD_CTS   = 3'd4,
    CMD_IDLE  = 3'd5,
    CMD_RSV6  = 3'd6,
    CMD_RSV7  = 3'd7
  } cmd_t;

  localparam logic [4:0] A_DATA  = 5'd0;
  localparam logic [4:0] A_FLAG  = 5'd6;
  localparam logic [4:0] A_IBRD  = 5'd9;
  localparam logic [4:0] A_FBRD  = 5'd10;
  localparam logic [4:0] A_LCRH  = 5'd11;
  localparam logic [4:0] A_CR    = 5'd12;
  localparam logic [4:0] A_IFLS  = 5'd13;
  localparam logic [4:0] A_IMSC  = 5'd14;
  localparam logic [4:0] A_RIS   = 5'd15;
  localparam logic [4:0] A_MIS   = 5'd16;
  localparam logic [4:0] A_ICR   = 5'd17;
  localparam logic [4:0] A_DMACR = 5'd18;

  localparam logic [10:0] STICKY_BITS = 11'h7C2;
  localparam logic [10:0] ST_OE  = 11'h400;
  localparam logic [10:0] ST_BE  = 11'h200;
  localparam logic [10:0] ST_PE  = 11'h100;
  localparam logic [10:0] ST_FE  = 11'h080;
  localparam logic [10:0] ST_RT  = 11'h040;
  localparam logic [10:0] ST_TX  = 11'h020;
  localparam logic [10:0] ST_RXL = 11'h010;
  localparam logic [10:0] ST_CTS = 11'h002;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  word_address;
    logic [15:0] write_data;
    logic [7:0]  rx_char;
    logic        rx_framing_error;
    logic        rx_parity_error;
    logic        rx_break;
    logic        cts_level;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        irq;
    logic        tx_valid;
    logic [7:0]  tx_data;
    logic        tx_break;
    logic        rts_out;
  } out_item_t;

  // level code to eighths of the depth; codes 4 and above act as 7/8
  function automatic int unsigned eighths(input logic [2:0] code);
    case (code)
      3'd0:    eighths = 1;
      3'd1:    eighths = 2;
      3'd2:    eighths = 4;
      3'd3:    eighths = 6;
      default: eighths = 7;
    endcase
  endfunction

  function automatic logic [7:0] word_mask(input logic [1:0] wlen);
    case (wlen)
      2'd0:    word_mask = 8'h1F;
      2'd1:    word_mask = 8'h3F;
      2'd2:    word_mask = 8'h7F;
      default: word_mask = 8'hFF;
    endcase
  endfunction

endpackage
`default_nettype wire

[design/uart_rb_fifo.sv]
// ----------------------------------------------------------------------------
// UART register block FIFO
// Circular buffer in a synchronous memory; pointers and fill kept by owner.
// ----------------------------------------------------------------------------
`default_nettype none
module uart_rb_fifo #(
  parameter int Depth = 32,
  parameter int Width = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[design/uart_register_block_with_fifos.sv]
// ----------------------------------------------------------------------------
// UART register block with FIFOs
// Bus registers, receive/transmit FIFOs, interrupt status.
// ----------------------------------------------------------------------------
// A transaction is accepted in ST_IDLE, where the FIFO memories are read at
// the head entries, and then ST_EXEC decodes and updates state. The result is
// registered at the end of ST_EXEC and shows on the out_ ports in the cycle
// after, with out_valid high for one cycle. busy is high during ST_EXEC, so a
// new start is not taken until the transaction has left ST_EXEC. Results
// cannot be held off by the receiver.
`default_nettype none
module uart_register_block_with_fifos #(
  parameter int FifoDepth    = uart_rb_pkg::FifoDepthDef,
  parameter int TimeoutTicks = uart_rb_pkg::TimeoutTicksDef
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire uart_rb_pkg::in_item_t  in_item,
  output logic                        out_valid,
  output uart_rb_pkg::out_item_t      out_item
);

  localparam int AW = $clog2(FifoDepth);
  localparam int CW = AW + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  uart_rb_pkg::in_item_t item_r;

  logic [CW-1:0] tx_count_r, tx_count_nxt, rx_count_r, rx_count_nxt;
  logic [AW-1:0] tx_head_r, tx_head_nxt, rx_head_r, rx_head_nxt;
  logic [7:0]  lcr_r, lcr_nxt;
  logic [15:0] cr_r, cr_nxt;
  logic [21:0] div_pend_r, div_pend_nxt, div_act_r, div_act_nxt;
  logic [5:0]  ifls_r, ifls_nxt;
  logic [10:0] imsc_r, imsc_nxt, ris_r, ris_nxt;
  logic [2:0]  dma_r, dma_nxt;
  logic        cts_r, cts_nxt, ovr_r, ovr_nxt;
  logic [5:0]  idle_r, idle_nxt;
  logic        out_valid_nxt;
  uart_rb_pkg::out_item_t out_nxt;

  logic          tx_we, rx_we;
  logic [AW-1:0] tx_waddr, rx_waddr;
  logic [7:0]    tx_wdata, tx_rdata;
  logic [11:0]   rx_wdata, rx_rdata;

  uart_rb_fifo #(.Depth(FifoDepth), .Width(8)) u_tx_fifo (
    .clk(clk), .wr_en(tx_we), .wr_addr(tx_waddr), .wr_data(tx_wdata),
    .rd_addr(tx_head_r), .rd_data(tx_rdata)
  );
  uart_rb_fifo #(.Depth(FifoDepth), .Width(12)) u_rx_fifo (
    .clk(clk), .wr_en(rx_we), .wr_addr(rx_waddr), .wr_data(rx_wdata),
    .rd_addr(rx_head_r), .rd_data(rx_rdata)
  );

  assign busy = (state_r == ST_EXEC);

  function automatic logic [CW-1:0] thresh(input logic [2:0] code);
    logic [CW+3:0] p;
    p = (CW+4)'(FifoDepth) * (CW+4)'(uart_rb_pkg::eighths(code));
    thresh = CW'(p >> 3);
  endfunction

  function automatic logic [10:0] status(
    input logic [10:0] ris, input logic [7:0] lcr, input logic [5:0] ifls,
    input logic [CW-1:0] txc, input logic [CW-1:0] rxc);
    logic [10:0] s;
    logic        rxl, txl;
    s = ris & uart_rb_pkg::STICKY_BITS;
    if (lcr[4]) begin
      rxl = rxc >= thresh(ifls[5:3]);
      txl = txc <= thresh(ifls[2:0]);
    end else begin
      rxl = rxc != '0;
      txl = txc == '0;
    end
    if (rxl) s = s | uart_rb_pkg::ST_RXL;
    if (txl) s = s | uart_rb_pkg::ST_TX;
    status = s;
  endfunction

  always_comb begin
    logic [CW-1:0] cap;
    logic [15:0]   rd;
    logic [11:0]   e;
    logic [10:0]   fs;
    state_nxt = state_r;
    tx_count_nxt = tx_count_r; rx_count_nxt = rx_count_r;
    tx_head_nxt = tx_head_r;   rx_head_nxt = rx_head_r;
    lcr_nxt = lcr_r; cr_nxt = cr_r; div_pend_nxt = div_pend_r;
    div_act_nxt = div_act_r; ifls_nxt = ifls_r; imsc_nxt = imsc_r;
    ris_nxt = ris_r; dma_nxt = dma_r; cts_nxt = cts_r; ovr_nxt = ovr_r;
    idle_nxt = idle_r;
    out_valid_nxt = 1'b0;
    out_nxt = '0;
    tx_we = 1'b0; rx_we = 1'b0;
    tx_waddr = AW'(tx_head_r + AW'(tx_count_r));
    rx_waddr = AW'(rx_head_r + AW'(rx_count_r));
    tx_wdata = item_r.write_data[7:0];
    e = {4'h0, item_r.rx_char & uart_rb_pkg::word_mask(lcr_r[6:5])};
    if (ovr_r) e[11] = 1'b1;
    if (item_r.rx_break) e[10] = 1'b1;
    if (item_r.rx_parity_error) e[9] = 1'b1;
    if (item_r.rx_framing_error) e[8] = 1'b1;
    rx_wdata = e;
    cap = lcr_r[4] ? CW'(FifoDepth) : CW'(1);
    rd = '0;
    fs = status(ris_r, lcr_r, ifls_r, tx_count_r, rx_count_r);

    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        out_valid_nxt = 1'b1;
        case (uart_rb_pkg::cmd_t'(item_r.command))
          uart_rb_pkg::CMD_READ: begin
            unique case (item_r.word_address)
              uart_rb_pkg::A_DATA: begin
                if (rx_count_r != '0) begin
                  rd = {4'h0, rx_rdata};
                  rx_head_nxt = AW'(rx_head_r + AW'(1));
                  rx_count_nxt = CW'(rx_count_r - CW'(1));
                  idle_nxt = '0;
                end
              end
              uart_rb_pkg::A_FLAG: begin
                rd[7] = tx_count_r == '0;
                rd[6] = rx_count_r >= cap;
                rd[5] = tx_count_r >= cap;
                rd[4] = rx_count_r == '0;
                rd[3] = tx_count_r != '0;
                rd[0] = cts_r;
              end
              uart_rb_pkg::A_IBRD:  rd = div_pend_r[21:6];
              uart_rb_pkg::A_FBRD:  rd = {10'h0, div_pend_r[5:0]};
              uart_rb_pkg::A_LCRH:  rd = {8'h0, lcr_r};
              uart_rb_pkg::A_CR:    rd = cr_r;
              uart_rb_pkg::A_IFLS:  rd = {10'h0, ifls_r};
              uart_rb_pkg::A_IMSC:  rd = {5'h0, imsc_r};
              uart_rb_pkg::A_RIS:   rd = {5'h0, fs};
              uart_rb_pkg::A_MIS:   rd = {5'h0, fs & imsc_r};
              uart_rb_pkg::A_DMACR: rd = {13'h0, dma_r};
              default: rd = '0;
            endcase
          end
          uart_rb_pkg::CMD_WRITE: begin
            unique case (item_r.word_address)
              uart_rb_pkg::A_DATA: begin
                if (tx_count_r < cap) begin
                  tx_we = 1'b1;
                  tx_count_nxt = CW'(tx_count_r + CW'(1));
                end
              end
              uart_rb_pkg::A_IBRD: div_pend_nxt = {item_r.write_data, div_pend_r[5:0]};
              uart_rb_pkg::A_FBRD:
                div_pend_nxt = {div_pend_r[21:6], item_r.write_data[5:0]};
              uart_rb_pkg::A_LCRH: begin
                if (lcr_r[4] != item_r.write_data[4]) begin
                  tx_count_nxt = '0; rx_count_nxt = '0;
                  tx_head_nxt = '0;  rx_head_nxt = '0;
                  ovr_nxt = 1'b0;    idle_nxt = '0;
                end
                lcr_nxt = item_r.write_data[7:0];
                div_act_nxt = div_pend_r;
              end
              uart_rb_pkg::A_CR:    cr_nxt = item_r.write_data;
              uart_rb_pkg::A_IFLS:  ifls_nxt = item_r.write_data[5:0];
              uart_rb_pkg::A_IMSC:  imsc_nxt = item_r.write_data[10:0];
              uart_rb_pkg::A_ICR:
                ris_nxt = ris_r & ~item_r.write_data[10:0] & uart_rb_pkg::STICKY_BITS;
              uart_rb_pkg::A_DMACR: dma_nxt = item_r.write_data[2:0];
              default: ;
            endcase
          end
          uart_rb_pkg::CMD_RX: begin
            idle_nxt = '0;
            if (rx_count_r >= cap) begin
              ovr_nxt = 1'b1;
              ris_nxt = ris_r | uart_rb_pkg::ST_OE;
            end else begin
              if (item_r.rx_break) ris_nxt = ris_nxt | uart_rb_pkg::ST_BE;
              if (item_r.rx_parity_error) ris_nxt = ris_nxt | uart_rb_pkg::ST_PE;
              if (item_r.rx_framing_error) ris_nxt = ris_nxt | uart_rb_pkg::ST_FE;
              ovr_nxt = 1'b0;
              rx_we = 1'b1;
              rx_count_nxt = CW'(rx_count_r + CW'(1));
            end
          end
          uart_rb_pkg::CMD_TX: begin
            if (tx_count_r != '0) begin
              out_nxt.tx_valid = 1'b1;
              out_nxt.tx_data = tx_rdata & uart_rb_pkg::word_mask(lcr_r[6:5]);
              tx_head_nxt = AW'(tx_head_r + AW'(1));
              tx_count_nxt = CW'(tx_count_r - CW'(1));
            end
          end
          uart_rb_pkg::CMD_CTS: begin
            if (item_r.cts_level != cts_r) begin
              cts_nxt = item_r.cts_level;
              ris_nxt = ris_r | uart_rb_pkg::ST_CTS;
            end
          end
          uart_rb_pkg::CMD_IDLE: begin
            if (rx_count_r == '0) begin
              idle_nxt = '0;
            end else if (idle_r < 6'(TimeoutTicks)) begin
              idle_nxt = 6'(idle_r + 6'd1);
              if (idle_nxt == 6'(TimeoutTicks)) ris_nxt = ris_r | uart_rb_pkg::ST_RT;
            end
          end
          default: ;
        endcase
        out_nxt.read_data = rd;
        out_nxt.irq = |(status(ris_nxt, lcr_nxt, ifls_nxt, tx_count_nxt, rx_count_nxt)
                        & imsc_nxt);
        out_nxt.tx_break = lcr_nxt[0];
        out_nxt.rts_out = cr_nxt[11];
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tx_count_r <= '0; rx_count_r <= '0; tx_head_r <= '0; rx_head_r <= '0;
      lcr_r <= '0; cr_r <= '0; div_pend_r <= '0; div_act_r <= '0;
      ifls_r <= '0; imsc_r <= '0; ris_r <= '0; dma_r <= '0;
      cts_r <= 1'b0; ovr_r <= 1'b0; idle_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tx_count_r <= tx_count_nxt; rx_count_r <= rx_count_nxt;
      tx_head_r <= tx_head_nxt;   rx_head_r <= rx_head_nxt;
      lcr_r <= lcr_nxt; cr_r <= cr_nxt; div_pend_r <= div_pend_nxt;
      div_act_r <= div_act_nxt; ifls_r <= ifls_nxt; imsc_r <= imsc_nxt;
      ris_r <= ris_nxt; dma_r <= dma_nxt; cts_r <= cts_nxt; ovr_r <= ovr_nxt;
      idle_r <= idle_nxt;
      out_valid <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) item_r <= in_item;
    out_item <= out_nxt;
  end

endmodule
`default_nettype wire

[design/uart_rb_checker.sv]
// ----------------------------------------------------------------------------
// UART register block port checker
// Timing of start, busy and the result strobe; tx_data is zero without tx_valid.
// ----------------------------------------------------------------------------
`default_nettype none
module uart_rb_checker (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   out_valid,
  input wire uart_rb_pkg::out_item_t out_item
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted transaction did not go busy");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy) else $error("result missing after busy");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without transaction");

  a_tx_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.tx_valid |-> out_item.tx_data == 8'h00)
    else $error("tx_data set without tx_valid");

endmodule

bind uart_register_block_with_fifos uart_rb_checker u_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
`default_nettype wire
